### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property including during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/vnrc_pkg.sv
package vnrc_pkg;

  typedef enum logic [1:0] {
    ACT_LOOKUP     = 2'd0,
    ACT_ADD        = 2'd1,
    ACT_INVALIDATE = 2'd2,
    ACT_EMIT       = 2'd3
  } action_t;

  localparam logic [2:0] KIND_CALL   = 3'd0;
  localparam logic [2:0] KIND_GSTORE = 3'd1;
  localparam logic [2:0] KIND_TWRITE = 3'd2;
  localparam logic [2:0] KIND_WDEST  = 3'd3;

  localparam logic [1:0] CFG_GLOBAL_LOAD = 2'd0;
  localparam logic [1:0] CFG_TGET_CONST  = 2'd1;
  localparam logic [1:0] CFG_TGET_INT    = 2'd2;

  localparam logic [8:0] NEG_ONE9 = 9'h1FF;

  // Operation decided by the front part
  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_ADD,
    OP_CLEAR,
    OP_SWEEP_REG,
    OP_SWEEP_GLOBAL,
    OP_SWEEP_TABLE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  opcode;
    logic [8:0]  left_source;
    logic [8:0]  right_source;
    logic [31:0] immediate;
    logic [8:0]  dest_register;
    logic [8:0]  target_register;
    logic [31:0] global_index;
  } cmd_t;

  typedef struct packed {
    logic       found;
    logic [8:0] found_register;
    logic [4:0] entries_used;
  } res_t;

endpackage

### rtl/core/vnrc_if.sv
interface vnrc_req_if;
  import vnrc_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  opcode;
  logic signed [8:0]  left_source;
  logic signed [8:0]  right_source;
  logic signed [31:0] immediate;
  logic signed [8:0]  dest_register;
  logic [2:0]  emit_kind;
  logic signed [8:0]  target_register;
  logic signed [31:0] global_index;
  modport source (output valid, action, opcode, left_source, right_source, immediate,
                  dest_register, emit_kind, target_register, global_index, input ready);
  modport sink (input valid, action, opcode, left_source, right_source, immediate,
                dest_register, emit_kind, target_register, global_index, output ready);
endinterface

interface vnrc_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic signed [8:0] found_register;
  logic [4:0]  entries_used;
  modport source (output valid, found, found_register, entries_used, input ready);
  modport sink (input valid, found, found_register, entries_used, output ready);
endinterface

interface vnrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/vnrc_front.sv
module vnrc_front
  import vnrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  vnrc_req_if.sink req,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic full;
  cmd_t slot;
  op_t  op_next;

  // Classify the request into one table operation
  always_comb begin
    op_next = OP_NONE;
    unique case (action_t'(req.action))
      ACT_LOOKUP:     op_next = OP_LOOKUP;
      ACT_ADD:        op_next = OP_ADD;
      ACT_INVALIDATE: op_next = OP_SWEEP_REG;
      ACT_EMIT: begin
        priority case (req.emit_kind)
          KIND_CALL:   op_next = OP_CLEAR;
          KIND_GSTORE: op_next = OP_SWEEP_GLOBAL;
          KIND_TWRITE: op_next = OP_SWEEP_TABLE;
          KIND_WDEST:  op_next = OP_SWEEP_REG;
          default:     op_next = OP_NONE;
        endcase
      end
      default: op_next = OP_NONE;
    endcase
  end

  // One-entry queue toward the back part
  assign req.ready = !full || cmd_ready;
  assign cmd_valid = full;
  assign cmd       = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (req.valid && req.ready) begin
      full <= 1'b1;
    end else if (cmd_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      slot.op              <= op_next;
      slot.opcode          <= req.opcode;
      slot.left_source     <= req.left_source;
      slot.right_source    <= req.right_source;
      slot.immediate       <= req.immediate;
      slot.dest_register   <= req.dest_register;
      slot.target_register <= req.target_register;
      slot.global_index    <= req.global_index;
    end
  end

endmodule

### rtl/core/vnrc_back.sv
module vnrc_back
  import vnrc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  input  logic [7:0] global_load_code,
  input  logic [7:0] table_get_const_code,
  input  logic [7:0] table_get_int_code,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] live_count
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t state;
  cmd_t   cur;
  logic [CW-1:0] idx;
  logic   found;
  logic [8:0] found_reg;

  logic [7:0]  t_op  [TABLE_DEPTH];
  logic [8:0]  t_l   [TABLE_DEPTH];
  logic [8:0]  t_r   [TABLE_DEPTH];
  logic [31:0] t_imm [TABLE_DEPTH];
  logic [8:0]  t_res [TABLE_DEPTH];

  logic [IW-1:0] ia, la, na;
  logic hit, doom, in_place;
  logic [CW-1:0] last;

  assign ia   = idx[IW-1:0];
  assign last = live_count - CW'(1);
  assign la   = last[IW-1:0];
  assign na   = live_count[IW-1:0];

  // Examine the current entry
  always_comb begin
    hit = t_op[ia] == cur.opcode && t_l[ia] == cur.left_source &&
          t_r[ia] == cur.right_source && t_imm[ia] == cur.immediate;
    doom = 1'b0;
    unique case (cur.op)
      OP_SWEEP_REG: doom = t_l[ia] == cur.target_register ||
                           t_r[ia] == cur.target_register ||
                           t_res[ia] == cur.target_register;
      OP_SWEEP_GLOBAL: doom = t_op[ia] == global_load_code &&
                              t_imm[ia] == cur.global_index;
      OP_SWEEP_TABLE: doom = (t_op[ia] == table_get_const_code ||
                              t_op[ia] == table_get_int_code) &&
                             t_l[ia] == cur.target_register;
      default: doom = 1'b0;
    endcase
    in_place = !cur.dest_register[8] && (cur.dest_register == cur.left_source ||
               cur.dest_register == cur.right_source);
  end

  assign cmd_ready = state == S_IDLE;
  assign res_valid = state == S_DONE;
  assign res.found = found;
  assign res.found_register = found_reg;
  assign res.entries_used = 5'(live_count);

  // Sequencer: one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            idx <= '0;
            found <= 1'b0;
            found_reg <= NEG_ONE9;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          state <= S_DONE;
          unique case (cur.op)
            OP_ADD: begin
              // Append at the slot just past the live entries
              if (!in_place && live_count < CW'(TABLE_DEPTH)) begin
                t_op[na]  <= cur.opcode;
                t_l[na]   <= cur.left_source;
                t_r[na]   <= cur.right_source;
                t_imm[na] <= cur.immediate;
                t_res[na] <= cur.dest_register;
                live_count <= live_count + CW'(1);
              end
            end
            OP_CLEAR: live_count <= '0;
            OP_LOOKUP: begin
              if (idx < live_count) begin
                if (hit) begin
                  found <= 1'b1;
                  found_reg <= t_res[ia];
                end else begin
                  idx <= idx + CW'(1);
                  state <= S_WALK;
                end
              end
            end
            OP_SWEEP_REG, OP_SWEEP_GLOBAL, OP_SWEEP_TABLE: begin
              if (idx < live_count) begin
                state <= S_WALK;
                if (doom) begin
                  live_count <= last;
                  t_op[ia]  <= t_op[la];
                  t_l[ia]   <= t_l[la];
                  t_r[ia]   <= t_r[la];
                  t_imm[ia] <= t_imm[la];
                  t_res[ia] <= t_res[la];
                end else begin
                  idx <= idx + CW'(1);
                end
              end
            end
            default: ;
          endcase
        end
        S_DONE: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/value_numbering_result_cache_top.sv
// Channel | Role   | Payload
// req     | sink   | action, opcode, sources, immediate, dest, emit kind, target, global
// rsp     | source | found, found_register, entries_used
// cfg     | sink   | index, data (three 8-bit opcode registers)
// A lookup walks entries until a hit, and a sweep visits every live entry;
// the back sequencer reads one entry a cycle.
// A one-entry queue separates request intake from the sequencer.
// Reset (rst, synchronous) empties the table and zeroes the opcode registers.
// A stalled response holds the sequencer; the queue still takes one request.
module value_numbering_result_cache_top
  import vnrc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  vnrc_req_if.sink    req,
  vnrc_rsp_if.source  rsp,
  vnrc_cfg_if.sink    cfg
);
  `include "assert_macros.svh"

  logic [7:0] global_load_code, table_get_const_code, table_get_int_code;
  logic cmd_valid, cmd_ready, res_valid;
  cmd_t cmd;
  res_t res;
  logic [$clog2(TABLE_DEPTH+1)-1:0] live_count;

  // Hold configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      global_load_code <= '0;
      table_get_const_code <= '0;
      table_get_int_code <= '0;
    end else if (cfg.valid) begin
      priority case (cfg.index)
        CFG_GLOBAL_LOAD: global_load_code <= cfg.data;
        CFG_TGET_CONST:  table_get_const_code <= cfg.data;
        CFG_TGET_INT:    table_get_int_code <= cfg.data;
        default: ;
      endcase
    end
  end

  vnrc_front u_front (
    .clk, .rst, .req, .cmd_valid, .cmd_ready, .cmd
  );

  vnrc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .global_load_code, .table_get_const_code, .table_get_int_code,
    .res_valid, .res_ready(rsp.ready), .res, .live_count
  );

  assign rsp.valid = res_valid;
  assign rsp.found = res.found;
  assign rsp.found_register = res.found_register;
  assign rsp.entries_used = res.entries_used;

  `ASSERT_CLK(a_count_bound, clk, rst, live_count <= TABLE_DEPTH, "live count above depth")
  `ASSERT_CLK(a_miss_neg, clk, rst, rsp.valid && !rsp.found |-> rsp.found_register == NEG_ONE9, "miss not -1")
  `ASSERT_CLK(a_hold, clk, rst, rsp.valid && !rsp.ready |=> rsp.valid && $stable(live_count), "table moved under stall")

endmodule

### tb/sv/vnrc_cache_checker.sv
module vnrc_cache_checker
  import vnrc_pkg::*;
(
  input logic   clk,
  input logic   rst,
  vnrc_req_if   req,
  vnrc_rsp_if   rsp,
  vnrc_cfg_if   cfg,
  output int    fail_count,
  output int    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [8:0]  left;
    logic [8:0]  right;
    logic [31:0] imm;
    logic [8:0]  result;
  } entry_t;

  entry_t     table_model [DEPTH];
  int         live;
  logic [7:0] gload_code, tget_const_code, tget_int_code;
  res_t       expected_q[$];

  typedef enum int { DROP_REG, DROP_GLOBAL, DROP_TABLE } drop_mode_t;

  // Decide whether an entry dies under the given sweep
  function automatic bit entry_dies(entry_t e, drop_mode_t mode, logic [8:0] r,
                                    logic [31:0] g);
    case (mode)
      DROP_REG:    return e.left == r || e.right == r || e.result == r;
      DROP_GLOBAL: return e.opcode == gload_code && e.imm == g;
      default:     return (e.opcode == tget_const_code || e.opcode == tget_int_code)
                          && e.left == r;
    endcase
  endfunction

  // Remove doomed entries; move the last entry in and recheck it
  task automatic compact_table(drop_mode_t mode, logic [8:0] r, logic [31:0] g);
    int i;
    i = 0;
    while (i < live) begin
      if (entry_dies(table_model[i], mode, r, g)) begin
        live--;
        table_model[i] = table_model[live];
      end else begin
        i++;
      end
    end
  endtask

  // Compute the response of one accepted request
  task automatic predict_response();
    res_t   r;
    entry_t e;
    bit     in_place;
    r.found = 1'b0;
    r.found_register = NEG_ONE9;
    e.opcode = req.opcode;
    e.left = req.left_source;
    e.right = req.right_source;
    e.imm = req.immediate;
    e.result = req.dest_register;
    case (action_t'(req.action))
      ACT_LOOKUP: begin
        for (int i = 0; i < live; i++) begin
          if (!r.found && table_model[i].opcode == e.opcode &&
              table_model[i].left == e.left && table_model[i].right == e.right &&
              table_model[i].imm == e.imm) begin
            r.found = 1'b1;
            r.found_register = table_model[i].result;
          end
        end
      end
      ACT_ADD: begin
        in_place = !e.result[8] && (e.result == e.left || e.result == e.right);
        if (!in_place && live < DEPTH) begin
          table_model[live] = e;
          live++;
        end
      end
      ACT_INVALIDATE: compact_table(DROP_REG, req.target_register, '0);
      default: begin
        case (req.emit_kind)
          KIND_CALL:   live = 0;
          KIND_GSTORE: compact_table(DROP_GLOBAL, '0, req.global_index);
          KIND_TWRITE: compact_table(DROP_TABLE, req.target_register, '0);
          KIND_WDEST:  compact_table(DROP_REG, req.target_register, '0);
          default: ;
        endcase
      end
    endcase
    r.entries_used = 5'(live);
    expected_q.push_back(r);
  endtask

  // Print one mismatch and count it
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    live = 0;
    gload_code = '0;
    tget_const_code = '0;
    tget_int_code = '0;
  end

  // Track config, predict requests, and check responses
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      live = 0;
      gload_code = '0;
      tget_const_code = '0;
      tget_int_code = '0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_GLOBAL_LOAD: gload_code = cfg.data;
          CFG_TGET_CONST:  tget_const_code = cfg.data;
          CFG_TGET_INT:    tget_int_code = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) predict_response();
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected response", 32'd0, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (rsp.found !== want.found)
            report_mismatch("found", 32'(rsp.found), 32'(want.found));
          if (rsp.found_register !== want.found_register)
            report_mismatch("found_register", 32'(unsigned'(rsp.found_register)),
                            32'(want.found_register));
          if (rsp.entries_used !== want.entries_used)
            report_mismatch("entries_used", 32'(rsp.entries_used),
                            32'(want.entries_used));
        end
      end
    end
    pending_count = expected_q.size();
  end
endmodule

### tb/sv/value_numbering_result_cache_top_tb.sv
module value_numbering_result_cache_top_tb;
  import vnrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  int   fail_count, pending_count;
  int   send_idle_pct, recv_idle_pct;
  bit   recv_hold;

  // Operand pools keep keys colliding so lookups and sweeps hit
  logic [7:0]  op_pool [4];
  logic [31:0] imm_pool [4];

  vnrc_req_if req ();
  vnrc_rsp_if rsp ();
  vnrc_cfg_if cfg ();

  value_numbering_result_cache_top dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  vnrc_cache_checker checker_inst (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop on a hang
  initial begin
    #2_000_000;
    $display("[value_numbering_result_cache_top] ERROR");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when asked
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [8:0] pick_reg();
    case ($urandom_range(9))
      0:       return 9'h1FF;
      1:       return 9'd255;
      2:       return 9'(255 - $urandom_range(7));
      default: return 9'($urandom_range(5));
    endcase
  endfunction

  // Send one request, holding it until accepted; valid drops only while idling
  task automatic send_request(logic [1:0] act, logic [7:0] opc, logic [8:0] l, logic [8:0] r,
                              logic [31:0] imm, logic [8:0] dst, logic [2:0] kind,
                              logic [8:0] tgt, logic [31:0] gidx);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.opcode <= opc;
    req.left_source <= l;
    req.right_source <= r;
    req.immediate <= imm;
    req.dest_register <= dst;
    req.emit_kind <= kind;
    req.target_register <= tgt;
    req.global_index <= gidx;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [1:0] act;
    logic [7:0] opc;
    logic [31:0] imm;
    act = 2'($urandom_range(3));
    if ($urandom_range(3) == 0) act = ACT_ADD;
    opc = ($urandom_range(7) == 0) ? 8'($urandom) : op_pool[$urandom_range(3)];
    imm = ($urandom_range(7) == 0) ? $urandom : imm_pool[$urandom_range(3)];
    send_request(act, opc, pick_reg(), pick_reg(), imm, pick_reg(),
                 3'($urandom_range(($urandom_range(3) == 0) ? 7 : 3)),
                 pick_reg(), ($urandom_range(1) == 0) ? imm : $urandom);
  endtask

  // Write one register; the caller drops valid after the last write
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
  endtask

  // Drop the request, wait for every response, then let the sequencer settle
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_codes(logic [7:0] g, logic [7:0] c, logic [7:0] i);
    write_reg(CFG_GLOBAL_LOAD, g);
    write_reg(CFG_TGET_CONST, c);
    write_reg(CFG_TGET_INT, i);
    cfg.valid <= 1'b0;
    op_pool[0] = g;
    op_pool[1] = c;
    op_pool[2] = i;
    op_pool[3] = 8'($urandom);
  endtask

  initial begin
    rst = 1'b1;
    recv_hold = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 59;
    req.valid = 1'b0;
    req.action = '0;
    req.opcode = '0;
    req.left_source = '0;
    req.right_source = '0;
    req.immediate = '0;
    req.dest_register = '0;
    req.emit_kind = '0;
    req.target_register = '0;
    req.global_index = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    for (int i = 0; i < 4; i++) imm_pool[i] = $urandom;
    imm_pool[0] = 32'h8000_0000;
    imm_pool[1] = 32'h7FFF_FFFF;
    op_pool = '{8'd0, 8'd0, 8'd0, 8'd9};
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset codes, extremes, in-place and full-table adds
    send_request(ACT_LOOKUP, 8'd0, 9'h1FF, 9'h1FF, 32'd0, 9'h1FF, 3'd0, 9'h1FF, 32'd0);
    send_request(ACT_ADD, 8'hFF, 9'd255, 9'h1FF, 32'h8000_0000, 9'd7, 3'd7, 9'd0, 32'd0);
    send_request(ACT_LOOKUP, 8'hFF, 9'd255, 9'h1FF, 32'h8000_0000, 9'd0, 3'd0, 9'd0, 32'd0);
    send_request(ACT_ADD, 8'd1, 9'd3, 9'd4, 32'd0, 9'd3, 3'd0, 9'd0, 32'd0);
    send_request(ACT_ADD, 8'd1, 9'd3, 9'd4, 32'd0, 9'd4, 3'd0, 9'd0, 32'd0);
    send_request(ACT_ADD, 8'd1, 9'h1FF, 9'h1FF, 32'd5, 9'h1FF, 3'd0, 9'd0, 32'd0);
    for (int i = 0; i < 17; i++)
      send_request(ACT_ADD, 8'(i), 9'(i), 9'd1, 32'h7FFF_FFFF, 9'd200, 3'd0, 9'd0, 32'd0);
    send_request(ACT_INVALIDATE, 8'd0, 9'd0, 9'd0, 32'd0, 9'd0, 3'd0, 9'd1, 32'd0);
    send_request(ACT_EMIT, 8'd0, 9'd0, 9'd0, 32'd0, 9'd0, 3'd5, 9'd0, 32'd0);
    send_request(ACT_EMIT, 8'd0, 9'd0, 9'd0, 32'd0, 9'd0, KIND_CALL, 9'd0, 32'd0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_codes(8'd0, 8'hFF, 8'd0);
        1: set_codes(8'hFF, 8'd0, 8'hFF);
        default: set_codes(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      send_idle_pct = (phase < 2) ? 22 : (phase < 4) ? 59 : 0;
      recv_idle_pct = (phase < 2) ? 59 : (phase < 4) ? 22 : 0;
      for (int n = 0; n < 250; n++) begin
        if (n == 100 && phase == 1) begin
          // Long receiver hold-off while requests keep coming
          recv_hold = 1'b1;
          fork
            begin
              repeat (300) @(negedge clk);
              recv_hold = 1'b0;
            end
          join_none
        end
        if (n == 200) begin
          req.valid <= 1'b0;
          while (pending_count != 0) @(negedge clk);
        end
        send_random();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[value_numbering_result_cache_top] OK");
    end else begin
      $display("[value_numbering_result_cache_top] ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/vnrc_pkg.sv
rtl/core/vnrc_if.sv
rtl/core/vnrc_front.sv
rtl/core/vnrc_back.sv
rtl/core/value_numbering_result_cache_top.sv
tb/sv/vnrc_cache_checker.sv
tb/sv/value_numbering_result_cache_top_tb.sv
